>>> rtl/core/ttrc_pkg.sv
// shared types and constants for the three-term recurrence checksum
package ttrc_pkg;

   localparam logic [7:0]  FIRST_OFFSET = 8'd7;
   localparam logic [7:0]  ALPHA_MUL    = 8'd17;
   localparam logic [7:0]  BETA_MUL     = 8'd31;
   localparam logic [16:0] SUM_MOD      = 17'd65535;

   localparam logic [15:0] TERM_RESET   = 16'd1;

   typedef struct packed {
      logic        in_message;
      logic [7:0]  byte_position;
      logic [15:0] older_term;
      logic [15:0] newer_term;
   } rec_state_type;

endpackage

>>> rtl/core/ttrc_step.sv
// one recurrence step: new checksum and next state from a byte and the current state
module ttrc_step
   import ttrc_pkg::*;
(
   input  logic [7:0]    data_byte,
   input  logic          last_byte,
   input  rec_state_type cur_state,
   output logic [15:0]   checksum,
   output rec_state_type next_state
);

   logic [7:0]  alpha;
   logic [7:0]  beta;
   logic [8:0]  coef;
   logic [24:0] prod_new;
   logic [23:0] prod_old;
   logic        no_borrow;
   logic [24:0] diff;
   logic [16:0] fold_sum;
   logic [15:0] fold_mod;
   logic [15:0] rec_result;
   logic [15:0] first_term;

   // position products only matter mod 256, so the low byte is enough
   assign alpha = 8'(cur_state.byte_position * ALPHA_MUL);
   assign beta  = 8'(cur_state.byte_position * BETA_MUL);
   assign coef  = {1'b0, data_byte} + {1'b0, alpha};

   assign prod_new = 25'(coef) * 25'(cur_state.newer_term);
   assign prod_old = 24'(beta) * 24'(cur_state.older_term);

   // 2^64 is 1 mod 65535, so a wrapped difference d reduces as -(|d| - 1)
   assign no_borrow = prod_new >= {1'b0, prod_old};
   assign diff      = no_borrow ? (prod_new - {1'b0, prod_old})
                                : ({1'b0, prod_old} - prod_new - 25'd1);

   // 65536 is 1 mod 65535: fold the high bits onto the low half
   assign fold_sum = {8'd0, diff[24:16]} + {1'b0, diff[15:0]};
   assign fold_mod = (fold_sum >= SUM_MOD) ? 16'(fold_sum - SUM_MOD) : fold_sum[15:0];

   always_comb begin
      if (no_borrow) begin
         rec_result = fold_mod;
      end else if (fold_mod == 16'd0) begin
         rec_result = 16'd0;
      end else begin
         rec_result = SUM_MOD[15:0] - fold_mod;
      end
   end

   assign first_term = {8'd0, data_byte} + {8'd0, FIRST_OFFSET};

   always_comb begin
      if (!cur_state.in_message) begin
         checksum                 = first_term;
         next_state.older_term    = TERM_RESET;
         next_state.newer_term    = first_term;
         next_state.byte_position = 8'd1;
         next_state.in_message    = 1'b1;
      end else begin
         checksum                 = rec_result;
         next_state.older_term    = cur_state.newer_term;
         next_state.newer_term    = rec_result;
         next_state.byte_position = cur_state.byte_position + 8'd1;
         next_state.in_message    = 1'b1;
      end
      if (last_byte) begin
         next_state.in_message    = 1'b0;
         next_state.byte_position = 8'd0;
      end
   end

endmodule

>>> rtl/core/ttrc_state.sv
// recurrence state registers: message flag, position and the two terms
module ttrc_state
   import ttrc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          update,
   input  rec_state_type state_in,
   output rec_state_type state_out
);

   rec_state_type state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.in_message    <= 1'b0;
         state_ff.byte_position <= 8'd0;
         state_ff.older_term    <= TERM_RESET;
         state_ff.newer_term    <= TERM_RESET;
      end else if (update) begin
         state_ff <= state_in;
      end
   end

   assign state_out = state_ff;

endmodule

>>> rtl/core/three_term_recurrence_checksum.sv
// top level of the three-term recurrence checksum
//
//   channel  direction  payload
//   req      in         req_data_byte[7:0], req_last_byte
//   rsp      out        rsp_checksum[15:0], rsp_done_res
//
// one byte per cycle sustained while rsp is not stalled; a byte lands in the
// input register at its transfer and moves into the result register, which
// drives rsp_valid, once the result register is free.
// the step logic (two small multiplies, subtract, fold mod 65535) sits between
// those registers and updates the state in place.
// reset clears the open-message flag and position and sets both terms to one.
// a stall on rsp holds the result register and backs up into req_stall.
module three_term_recurrence_checksum
   import ttrc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_checksum,
   output logic        rsp_done_res
);

   logic          in_valid_ff;
   logic          in_valid_in;
   logic [7:0]    in_byte_ff;
   logic          in_last_ff;
   logic          out_valid_ff;
   logic          out_valid_in;
   logic [15:0]   out_sum_ff;
   logic          out_done_ff;
   logic          out_free;
   logic          fire;
   logic          in_load;
   logic [15:0]   step_sum;
   rec_state_type cur_state;
   rec_state_type next_state;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign in_load   = !req_stall;

   assign in_valid_in  = in_load ? req_valid : in_valid_ff;
   assign out_valid_in = out_free ? in_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
   end

   // result register takes the step output on each transfer through the core
   always_ff @(posedge clock) begin
      if (fire) begin
         out_sum_ff  <= step_sum;
         out_done_ff <= in_last_ff;
      end
   end

   ttrc_step u_step (
      .data_byte  (in_byte_ff),
      .last_byte  (in_last_ff),
      .cur_state  (cur_state),
      .checksum   (step_sum),
      .next_state (next_state)
   );

   ttrc_state u_state (
      .clock     (clock),
      .reset     (reset),
      .update    (fire),
      .state_in  (next_state),
      .state_out (cur_state)
   );

   assign rsp_valid    = out_valid_ff;
   assign rsp_checksum = out_sum_ff;
   assign rsp_done_res = out_done_ff;

endmodule
